// ----- sv/gpioc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gpioc_pkg;

  localparam int unsigned NUM_PINS = 32;
  localparam int unsigned WORD_W   = 32;

  // pins at or above NUM_PINS never take part in interrupt evaluation
  localparam logic [WORD_W-1:0] PIN_MASK = WORD_W'((64'd1 << NUM_PINS) - 64'd1);

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_PIN   = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    REG_DIR  = 3'd0,
    REG_OUT  = 3'd1,
    REG_IN   = 3'd2,
    REG_IE   = 3'd3,
    REG_IS   = 3'd4,
    REG_TRIG = 3'd5,
    REG_POL  = 3'd6
  } reg_e;

  // per-pin interrupt setup handed to the evaluation logic
  typedef struct packed {
    logic [WORD_W-1:0] enable;
    logic [WORD_W-1:0] trig_level;
    logic [WORD_W-1:0] pol_high;
  } irq_cfg_t;

endpackage

`default_nettype wire

// ----- sv/gpioc_eval.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gpioc_eval import gpioc_pkg::*; (
  input  wire irq_cfg_t          cfg_i,
  input  wire logic [WORD_W-1:0] prev_i,
  input  wire logic [WORD_W-1:0] now_i,
  input  wire logic [WORD_W-1:0] status_i,
  output logic      [WORD_W-1:0] status_o
);

  logic [WORD_W-1:0] rise, fall, lvl_hit, edge_hit, hit, set_bits, clr_bits;

  always_comb begin
    rise     = ~prev_i & now_i;
    fall     = prev_i & ~now_i;
    lvl_hit  = (cfg_i.pol_high & now_i) | (~cfg_i.pol_high & ~now_i);
    edge_hit = (cfg_i.pol_high & rise) | (~cfg_i.pol_high & fall);
    hit      = (cfg_i.trig_level & lvl_hit) | (~cfg_i.trig_level & edge_hit);
    set_bits = cfg_i.enable & hit & PIN_MASK;
    // level pins that miss their condition or are not enabled drop status
    clr_bits = cfg_i.trig_level & ~set_bits & PIN_MASK;
    status_o = (status_i | set_bits) & ~clr_bits;
  end

endmodule

`default_nettype wire

// ----- sv/gpio_controller_with_interrupts_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// throughput: one command per cycle, busy_o stays low; input register, then one
// pass of per-pin logic into the state and result registers
// the receiver cannot stall, each result shows for exactly one cycle on done_o
// reset (rst_ni low, async) clears all pin registers: all pins input, edge mode,
// falling polarity, no status
module gpio_controller_with_interrupts_core import gpioc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [1:0]        op_i,
  input  wire logic [2:0]        reg_index_i,
  input  wire logic [WORD_W-1:0] write_data_i,
  input  wire logic              full_word_i,
  input  wire logic [4:0]        pin_number_i,
  input  wire logic              pin_value_i,
  output logic                   done_o,
  output logic      [WORD_W-1:0] read_data_o,
  output logic      [WORD_W-1:0] pin_drive_o,
  output logic                   irq_line_o
);

  // input register
  logic              valid_q;
  logic [1:0]        op_q;
  logic [2:0]        idx_q;
  logic [WORD_W-1:0] wdata_q;
  logic              full_q;
  logic [4:0]        pin_q;
  logic              pval_q;

  // pin state
  logic [WORD_W-1:0] dir_q, dir_d;
  logic [WORD_W-1:0] out_q, out_d;
  logic [WORD_W-1:0] ie_q, ie_d;
  logic [WORD_W-1:0] is_q, is_d, is_pre;
  logic [WORD_W-1:0] trig_q, trig_d;
  logic [WORD_W-1:0] pol_q, pol_d;
  logic [WORD_W-1:0] ext_q, ext_d;
  logic [WORD_W-1:0] prev_q, prev_d;

  // result register
  logic              done_q;
  logic [WORD_W-1:0] rdata_q, rdata_d;
  logic [WORD_W-1:0] drive_q;
  logic              irq_q;

  logic              eval;
  logic [WORD_W-1:0] pin_mask;
  logic [WORD_W-1:0] level_now;
  logic [WORD_W-1:0] is_eval;
  irq_cfg_t          cfg;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q    <= op_i;
      idx_q   <= reg_index_i;
      wdata_q <= write_data_i;
      full_q  <= full_word_i;
      pin_q   <= pin_number_i;
      pval_q  <= pin_value_i;
    end
  end

  assign pin_mask = WORD_W'(1) << pin_q;

  always_comb begin
    dir_d   = dir_q;
    out_d   = out_q;
    ie_d    = ie_q;
    is_pre  = is_q;
    trig_d  = trig_q;
    pol_d   = pol_q;
    ext_d   = ext_q;
    eval    = 1'b0;
    rdata_d = '0;
    if (valid_q) begin
      unique case (op_q)
        OP_READ: begin
          if (full_q) begin
            unique case (idx_q)
              REG_DIR:  rdata_d = dir_q;
              REG_OUT:  rdata_d = out_q;
              REG_IN:   rdata_d = (out_q & dir_q) | (ext_q & ~dir_q);
              REG_IE:   rdata_d = ie_q;
              REG_IS:   rdata_d = is_q;
              REG_TRIG: rdata_d = trig_q;
              REG_POL:  rdata_d = pol_q;
              default:  rdata_d = '0;
            endcase
          end
        end
        OP_WRITE: begin
          if (full_q) begin
            eval = 1'b1;
            unique case (idx_q)
              REG_DIR:  dir_d  = wdata_q;
              REG_OUT:  out_d  = wdata_q;
              REG_IE:   ie_d   = wdata_q;
              REG_IS:   is_pre = is_q & ~wdata_q;
              REG_TRIG: trig_d = wdata_q;
              REG_POL:  pol_d  = wdata_q;
              default:  eval   = 1'b0;
            endcase
          end
        end
        OP_PIN: begin
          // level changes on output pins are dropped
          if (({1'b0, pin_q} < 6'(NUM_PINS)) && ((dir_q & pin_mask) == '0)) begin
            ext_d = pval_q ? (ext_q | pin_mask) : (ext_q & ~pin_mask);
            eval  = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign level_now      = (out_d & dir_d) | (ext_d & ~dir_d);
  assign cfg.enable     = ie_d;
  assign cfg.trig_level = trig_d;
  assign cfg.pol_high   = pol_d;

  gpioc_eval u_eval (
    .cfg_i    (cfg),
    .prev_i   (prev_q),
    .now_i    (level_now),
    .status_i (is_pre),
    .status_o (is_eval)
  );

  assign is_d   = eval ? is_eval : is_pre;
  assign prev_d = eval ? level_now : prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= '0;
      out_q   <= '0;
      ie_q    <= '0;
      is_q    <= '0;
      trig_q  <= '0;
      pol_q   <= '0;
      ext_q   <= '0;
      prev_q  <= '0;
      done_q  <= 1'b0;
      drive_q <= '0;
      irq_q   <= 1'b0;
    end else begin
      dir_q   <= dir_d;
      out_q   <= out_d;
      ie_q    <= ie_d;
      is_q    <= is_d;
      trig_q  <= trig_d;
      pol_q   <= pol_d;
      ext_q   <= ext_d;
      prev_q  <= prev_d;
      done_q  <= valid_q;
      drive_q <= out_d & dir_d;
      irq_q   <= (is_d & ie_d) != '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_q) begin
      rdata_q <= rdata_d;
    end
  end

  assign done_o      = done_q;
  assign read_data_o = rdata_q;
  assign pin_drive_o = drive_q;
  assign irq_line_o  = irq_q;

  // every accepted command is followed by its result strobe, through the input and result registers
  a_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##2 done_o)
    else $error("command without result strobe");

  a_no_extra_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 2))
    else $error("result strobe without command");

  // result outputs track the state registers they were formed from
  a_irq_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    irq_line_o == ((is_q & ie_q) != '0))
    else $error("irq line disagrees with status and enable");

  a_drive_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pin_drive_o == (out_q & dir_q))
    else $error("pin drive disagrees with latch and direction");

endmodule

`default_nettype wire

// ----- tb/sv/gpio_controller_with_interrupts_core_tb.sv -----
`timescale 1ns / 1ps

module gpio_controller_with_interrupts_core_tb;
  import gpioc_pkg::*;

  // codes the field widths allow but the package leaves unnamed
  localparam logic [1:0] OP_NONE  = 2'd3;
  localparam logic [2:0] REG_NONE = 3'd7;

  typedef struct packed {
    logic [1:0]        op;
    logic [2:0]        idx;
    logic [WORD_W-1:0] data;
    logic              full;
    logic [4:0]        pin;
    logic              val;
  } gpio_cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic [WORD_W-1:0] pin_drive;
    logic              irq_line;
  } gpio_result_t;

  typedef struct packed {
    gpio_cmd_t    cmd;
    logic         typed;
    gpio_result_t res;
  } gpio_row_t;

  localparam gpio_result_t ZERO_RES = '{default: '0};
  localparam logic [WORD_W-1:0] ONES = '1;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [1:0]        op_i;
  logic [2:0]        reg_index_i;
  logic [WORD_W-1:0] write_data_i;
  logic              full_word_i;
  logic [4:0]        pin_number_i;
  logic              pin_value_i;
  logic              done_o;
  logic [WORD_W-1:0] read_data_o;
  logic [WORD_W-1:0] pin_drive_o;
  logic              irq_line_o;

  gpio_controller_with_interrupts_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .op_i        (op_i),
    .reg_index_i (reg_index_i),
    .write_data_i(write_data_i),
    .full_word_i (full_word_i),
    .pin_number_i(pin_number_i),
    .pin_value_i (pin_value_i),
    .done_o      (done_o),
    .read_data_o (read_data_o),
    .pin_drive_o (pin_drive_o),
    .irq_line_o  (irq_line_o)
  );

  // predicted pin registers
  logic [WORD_W-1:0] dir_word;
  logic [WORD_W-1:0] out_word;
  logic [WORD_W-1:0] ie_word;
  logic [WORD_W-1:0] is_word;
  logic [WORD_W-1:0] trig_word;
  logic [WORD_W-1:0] pol_word;
  logic [WORD_W-1:0] ext_word;
  logic [WORD_W-1:0] prev_level;

  gpio_result_t expected_results[$];
  int           mismatches;

  // directed commands: extremes, every register and each ignored case
  gpio_row_t directed_rows[$] = '{
    // state right after reset
    '{'{OP_READ,  REG_DIR,  32'h0, 1'b1, 5'd0,  1'b0}, 1'b1, ZERO_RES},
    // read of the unused register index
    '{'{OP_READ,  REG_NONE, ONES,  1'b1, 5'd31, 1'b1}, 1'b1, ZERO_RES},
    // narrow write is dropped
    '{'{OP_WRITE, REG_DIR,  ONES,  1'b0, 5'd0,  1'b0}, 1'b1, ZERO_RES},
    '{'{OP_WRITE, REG_OUT,  ONES,  1'b1, 5'd0,  1'b0}, 1'b1, ZERO_RES},
    // narrow read returns zero
    '{'{OP_READ,  REG_OUT,  32'h0, 1'b0, 5'd0,  1'b0}, 1'b1, ZERO_RES},
    '{'{OP_WRITE, REG_IE,   ONES,  1'b1, 5'd0,  1'b0}, 1'b1, ZERO_RES},
    '{'{OP_PIN,   REG_DIR,  32'h0, 1'b0, 5'd0,  1'b1}, 1'b0, ZERO_RES},
    '{'{OP_PIN,   REG_DIR,  32'h0, 1'b0, 5'd0,  1'b0}, 1'b0, ZERO_RES},
    '{'{OP_READ,  REG_IS,   32'h0, 1'b1, 5'd0,  1'b0}, 1'b0, ZERO_RES},
    '{'{OP_WRITE, REG_IS,   ONES,  1'b1, 5'd0,  1'b0}, 1'b0, ZERO_RES},
    '{'{OP_WRITE, REG_POL,  ONES,  1'b1, 5'd0,  1'b0}, 1'b0, ZERO_RES},
    '{'{OP_PIN,   REG_DIR,  32'h0, 1'b0, 5'd31, 1'b1}, 1'b0, ZERO_RES},
    '{'{OP_WRITE, REG_TRIG, ONES,  1'b1, 5'd0,  1'b0}, 1'b0, ZERO_RES},
    '{'{OP_READ,  REG_TRIG, 32'h0, 1'b1, 5'd0,  1'b0}, 1'b0, ZERO_RES},
    '{'{OP_WRITE, REG_POL,  32'h0, 1'b1, 5'd0,  1'b0}, 1'b0, ZERO_RES},
    '{'{OP_READ,  REG_IN,   32'h0, 1'b1, 5'd0,  1'b0}, 1'b0, ZERO_RES},
    '{'{OP_WRITE, REG_DIR,  ONES,  1'b1, 5'd0,  1'b0}, 1'b0, ZERO_RES},
    // pin change on an output pin is dropped
    '{'{OP_PIN,   REG_DIR,  32'h0, 1'b0, 5'd5,  1'b1}, 1'b0, ZERO_RES},
    '{'{OP_READ,  REG_POL,  32'h0, 1'b1, 5'd0,  1'b0}, 1'b0, ZERO_RES},
    // writes to the read-only and unused indexes
    '{'{OP_WRITE, REG_IN,   32'h12345678, 1'b1, 5'd0, 1'b0}, 1'b0, ZERO_RES},
    '{'{OP_WRITE, REG_NONE, 32'h0, 1'b1, 5'd0,  1'b0}, 1'b0, ZERO_RES},
    '{'{OP_NONE,  REG_OUT,  ONES,  1'b1, 5'd7,  1'b1}, 1'b0, ZERO_RES},
    '{'{OP_WRITE, REG_OUT,  32'h5a5aa5a5, 1'b1, 5'd0, 1'b0}, 1'b0, ZERO_RES},
    '{'{OP_READ,  REG_IS,   32'h0, 1'b1, 5'd0,  1'b0}, 1'b0, ZERO_RES},
    '{'{OP_WRITE, REG_DIR,  32'h0, 1'b1, 5'd0,  1'b0}, 1'b0, ZERO_RES}
  };

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [WORD_W-1:0] pin_levels();
    return (out_word & dir_word) | (ext_word & ~dir_word);
  endfunction

  function automatic void update_irq_status();
    logic [WORD_W-1:0] now;
    logic [WORD_W-1:0] rise;
    logic [WORD_W-1:0] fall;
    logic [WORD_W-1:0] level_hit;
    logic [WORD_W-1:0] edge_hit;
    logic [WORD_W-1:0] set_bits;
    logic [WORD_W-1:0] clr_bits;
    now       = pin_levels();
    rise      = ~prev_level & now;
    fall      = prev_level & ~now;
    level_hit = (pol_word & now) | (~pol_word & ~now);
    edge_hit  = (pol_word & rise) | (~pol_word & fall);
    set_bits  = ie_word & ((trig_word & level_hit) | (~trig_word & edge_hit)) & PIN_MASK;
    // level pins that miss their condition or are not enabled drop their status
    clr_bits  = trig_word & ~set_bits & PIN_MASK;
    is_word    = (is_word | set_bits) & ~clr_bits;
    prev_level = now;
  endfunction

  function automatic gpio_result_t predict_gpio(input gpio_cmd_t c);
    gpio_result_t      r;
    logic [WORD_W-1:0] m;
    logic              do_eval;
    r       = ZERO_RES;
    do_eval = 1'b0;
    m       = WORD_W'(1) << c.pin;
    if (c.op == OP_READ && c.full) begin
      case (c.idx)
        REG_DIR:  r.read_data = dir_word;
        REG_OUT:  r.read_data = out_word;
        REG_IN:   r.read_data = pin_levels();
        REG_IE:   r.read_data = ie_word;
        REG_IS:   r.read_data = is_word;
        REG_TRIG: r.read_data = trig_word;
        REG_POL:  r.read_data = pol_word;
        default:  r.read_data = '0;
      endcase
    end else if (c.op == OP_WRITE && c.full) begin
      do_eval = 1'b1;
      case (c.idx)
        REG_DIR:  dir_word  = c.data;
        REG_OUT:  out_word  = c.data;
        REG_IE:   ie_word   = c.data;
        REG_IS:   is_word   = is_word & ~c.data;
        REG_TRIG: trig_word = c.data;
        REG_POL:  pol_word  = c.data;
        default:  do_eval   = 1'b0;
      endcase
    end else if (c.op == OP_PIN && c.pin < NUM_PINS && (dir_word & m) == '0) begin
      ext_word = c.val ? (ext_word | m) : (ext_word & ~m);
      do_eval  = 1'b1;
    end
    if (do_eval) begin
      update_irq_status();
    end
    r.pin_drive = out_word & dir_word;
    r.irq_line  = |(is_word & ie_word);
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $urandom_range(1) ? ONES : '0;
      2:       return WORD_W'(1) << $urandom_range(WORD_W - 1);
      default: return $urandom & $urandom;
    endcase
  endfunction

  function automatic gpio_cmd_t rand_cmd();
    gpio_cmd_t c;
    int        sel;
    sel    = $urandom_range(99);
    c.idx  = 3'($urandom_range(7));
    c.data = rand_word();
    c.full = 1'($urandom_range(1));
    c.pin  = 5'($urandom_range(31));
    c.val  = 1'($urandom_range(1));
    if (sel < 40) begin
      c.op = OP_PIN;
    end else if (sel < 75) begin
      c.op   = OP_WRITE;
      c.full = ($urandom_range(9) != 0);
    end else if (sel < 97) begin
      c.op   = OP_READ;
      c.full = ($urandom_range(9) != 0);
    end else begin
      c.op = OP_NONE;
    end
    return c;
  endfunction

  // one command transfer; the prediction is queued at the accepting edge
  task automatic issue(input gpio_cmd_t c, input logic typed, input gpio_result_t typed_res);
    gpio_result_t r;
    op_i         <= c.op;
    reg_index_i  <= c.idx;
    write_data_i <= c.data;
    full_word_i  <= c.full;
    pin_number_i <= c.pin;
    pin_value_i  <= c.val;
    start_i      <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    r = predict_gpio(c);
    expected_results.push_back(typed ? typed_res : r);
  endtask

  task automatic sender_gap(input int pct);
    if ($urandom_range(99) < pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < pct);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  // result checker
  always @(posedge clk_i) begin
    gpio_result_t e;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatches++;
      end else begin
        e = expected_results.pop_front();
        if (read_data_o !== e.read_data) begin
          $error("read_data: expected %h, got %h", e.read_data, read_data_o);
          mismatches++;
        end
        if (pin_drive_o !== e.pin_drive) begin
          $error("pin_drive: expected %h, got %h", e.pin_drive, pin_drive_o);
          mismatches++;
        end
        if (irq_line_o !== e.irq_line) begin
          $error("irq_line: expected %b, got %b", e.irq_line, irq_line_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int idle_pct[3];
    int waited;
    idle_pct     = '{20, 75, 0};
    mismatches   = 0;
    dir_word     = '0;
    out_word     = '0;
    ie_word      = '0;
    is_word      = '0;
    trig_word    = '0;
    pol_word     = '0;
    ext_word     = '0;
    prev_level   = '0;
    rst_ni       <= 1'b0;
    start_i      <= 1'b0;
    op_i         <= OP_READ;
    reg_index_i  <= REG_DIR;
    write_data_i <= '0;
    full_word_i  <= 1'b0;
    pin_number_i <= '0;
    pin_value_i  <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      issue(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].res);
    end
    drain();

    foreach (idle_pct[p]) begin
      repeat (430) begin
        sender_gap(idle_pct[p]);
        issue(rand_cmd(), 1'b0, ZERO_RES);
      end
      // hold off until every queued result has come back
      drain();
    end

    waited = 0;
    while (expected_results.size() != 0 && waited < 100) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("gpio_controller_with_interrupts_core verification clean");
    end else begin
      $display("gpio_controller_with_interrupts_core verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("gpio_controller_with_interrupts_core verification failed");
    $finish;
  end

endmodule
